>>> hw/rtl/vfcm_pkg.sv
// Shared types, codes and corner tables of the voxel face-culling mesher.
package vfcm_pkg;

	localparam int CHUNK_WIDTH_DEF  = 16;
	localparam int CHUNK_HEIGHT_DEF = 256;
	localparam int TYPE_BITS_DEF    = 8;

	// Coordinate width that holds a neighbor step and its underflow wrap.
	localparam int CRD_W = 9;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_MESH  = 1'b1;

	localparam logic [1:0] REG_CHUNK_POS_X = 2'd0;
	localparam logic [1:0] REG_CHUNK_POS_Z = 2'd1;
	localparam logic [1:0] REG_EMPTY_CODE  = 2'd2;

	localparam logic [2:0] FACE_BACK   = 3'd0;
	localparam logic [2:0] FACE_FRONT  = 3'd1;
	localparam logic [2:0] FACE_BOTTOM = 3'd2;
	localparam logic [2:0] FACE_TOP    = 3'd3;
	localparam logic [2:0] FACE_LEFT   = 3'd4;
	localparam logic [2:0] FACE_RIGHT  = 3'd5;

	localparam logic [2:0] VTX_LAST = 3'd5;

	// Corner bits, high to low: dx, dy, dz, tex_u, tex_v.
	typedef logic [4:0] corner_t;

	localparam corner_t CORNER_TAB [0:5][0:5] = '{
		'{5'b10000, 5'b11001, 5'b00010, 5'b11001, 5'b01011, 5'b00010},
		'{5'b00100, 5'b01101, 5'b10110, 5'b01101, 5'b11111, 5'b10110},
		'{5'b00000, 5'b00101, 5'b10010, 5'b00101, 5'b10111, 5'b10010},
		'{5'b11000, 5'b11101, 5'b01010, 5'b11101, 5'b01111, 5'b01010},
		'{5'b00000, 5'b01001, 5'b00110, 5'b01001, 5'b01111, 5'b00110},
		'{5'b10100, 5'b11101, 5'b10010, 5'b11101, 5'b11011, 5'b10010}
	};

	typedef struct packed {
		logic [7:0] vert_x;
		logic [7:0] vert_y;
		logic [7:0] vert_z;
		logic       tex_u;
		logic       tex_v;
		logic [2:0] face;
		logic       last;
	} vtx_t;

	// Lowest visible face at or above start; MSB flags a hit.
	function automatic logic [3:0] next_face(input logic [5:0] mask, input logic [2:0] start);
		logic [3:0] res;
		res = '0;
		for (int i = 5; i >= 0; i--) begin
			if (mask[i] && (3'(i) >= start)) begin
				res = {1'b1, 3'(i)};
			end
		end
		return res;
	endfunction

endpackage

>>> hw/rtl/vfcm_store.sv
// Cell type store: single-port synchronous memory with a clearing pass after reset.
module vfcm_store #(
	parameter int ADDR_W    = 16,
	parameter int TYPE_BITS = vfcm_pkg::TYPE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we,
	input  logic [ADDR_W-1:0]    addr,
	input  logic [TYPE_BITS-1:0] wdata,
	output logic [TYPE_BITS-1:0] rdata,
	output logic                 clr_busy
);

	logic [TYPE_BITS-1:0] mem [0:(1 << ADDR_W)-1];
	logic [ADDR_W-1:0]    clr_q;
	logic                 busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + ADDR_W'(1);
			if (&clr_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

	assign clr_busy = busy_q;

endmodule

>>> hw/rtl/vfcm_ctrl.sv
// Command sequencer: store writes, neighbor reads, face culling and vertex emission.
module vfcm_ctrl #(
	parameter int CHUNK_WIDTH  = vfcm_pkg::CHUNK_WIDTH_DEF,
	parameter int CHUNK_HEIGHT = vfcm_pkg::CHUNK_HEIGHT_DEF,
	parameter int TYPE_BITS    = vfcm_pkg::TYPE_BITS_DEF,
	localparam int XB = $clog2(CHUNK_WIDTH),
	localparam int YB = $clog2(CHUNK_HEIGHT),
	localparam int AW = 2 * XB + YB
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clr_busy,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic [3:0]           cell_x,
	input  logic [7:0]           cell_y,
	input  logic [3:0]           cell_z,
	input  logic [7:0]           cell_type,
	input  logic [7:0]           empty_code,
	output logic                 mem_we,
	output logic [AW-1:0]        mem_addr,
	output logic [TYPE_BITS-1:0] mem_wdata,
	input  logic [TYPE_BITS-1:0] mem_rdata,
	output logic                 out_valid,
	input  logic                 out_ready,
	output vfcm_pkg::vtx_t       out_vtx
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_WAIT = 3'd2;
	localparam logic [2:0] ST_DEC  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	localparam logic [2:0] SLOT_CENTER = 3'd0;
	localparam logic [2:0] SLOT_LAST   = 3'd6;

	localparam int CW = vfcm_pkg::CRD_W;

	logic [2:0]           state_q;
	logic [3:0]           x_q;
	logic [7:0]           y_q;
	logic [3:0]           z_q;
	logic [2:0]           rd_q;
	logic                 chk_vld_s1;
	logic [2:0]           chk_idx_s1;
	logic                 chk_in_s1;
	logic                 ctr_full_q;
	logic [5:0]           mask_q;
	logic [2:0]           face_q;
	logic [2:0]           vtx_q;
	logic                 out_valid_q;
	vfcm_pkg::vtx_t       out_vtx_q;

	logic [CW-1:0]        nx, ny, nz;
	logic [CW-1:0]        ix, iy, iz;
	logic [2:0]           nb_face;
	logic                 nb_in;
	logic                 in_in;
	logic                 acc;
	logic [15:0]          type16;
	logic [15:0]          empty16;
	logic [TYPE_BITS-1:0] empty_t;
	logic                 rd_empty;
	logic [2:0]           nf_start;
	logic [3:0]           nf;
	vfcm_pkg::corner_t    corner;
	logic                 load;
	logic                 is_last;

	assign nb_face = rd_q - 3'd1;

	always_comb begin
		nx = CW'(x_q);
		ny = CW'(y_q);
		nz = CW'(z_q);
		if (rd_q != SLOT_CENTER) begin
			unique case (nb_face)
				vfcm_pkg::FACE_BACK:   nz = nz - CW'(1);
				vfcm_pkg::FACE_FRONT:  nz = nz + CW'(1);
				vfcm_pkg::FACE_BOTTOM: ny = ny - CW'(1);
				vfcm_pkg::FACE_TOP:    ny = ny + CW'(1);
				vfcm_pkg::FACE_LEFT:   nx = nx - CW'(1);
				vfcm_pkg::FACE_RIGHT:  nx = nx + CW'(1);
				default: ;
			endcase
		end
	end

	assign nb_in = (nx < CW'(CHUNK_WIDTH)) && (ny < CW'(CHUNK_HEIGHT)) &&
		(nz < CW'(CHUNK_WIDTH));

	assign ix    = CW'(cell_x);
	assign iy    = CW'(cell_y);
	assign iz    = CW'(cell_z);
	assign in_in = (ix < CW'(CHUNK_WIDTH)) && (iy < CW'(CHUNK_HEIGHT)) &&
		(iz < CW'(CHUNK_WIDTH));

	assign in_ready = (state_q == ST_IDLE) && !clr_busy;
	assign acc      = in_valid && in_ready;

	assign type16    = 16'(cell_type);
	assign empty16   = 16'(empty_code);
	assign empty_t   = empty16[TYPE_BITS-1:0];
	assign mem_wdata = type16[TYPE_BITS-1:0];
	assign mem_we    = acc && (cmd == vfcm_pkg::CMD_WRITE) && in_in;
	assign mem_addr  = (state_q == ST_IDLE) ?
		{ix[XB-1:0], iy[YB-1:0], iz[XB-1:0]} :
		{nx[XB-1:0], ny[YB-1:0], nz[XB-1:0]};

	assign rd_empty = !chk_in_s1 || (mem_rdata == empty_t);

	assign nf_start = (state_q == ST_DEC) ? 3'd0 : face_q + 3'd1;
	assign nf       = vfcm_pkg::next_face(mask_q, nf_start);

	assign corner  = vfcm_pkg::CORNER_TAB[face_q][vtx_q];
	assign load    = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign is_last = (vtx_q == vfcm_pkg::VTX_LAST) && !nf[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_q        <= '0;
			chk_vld_s1  <= 1'b0;
			face_q      <= '0;
			vtx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			chk_vld_s1 <= (state_q == ST_RD);
			unique case (state_q)
				ST_IDLE: begin
					if (acc && (cmd == vfcm_pkg::CMD_MESH) && in_in) begin
						state_q <= ST_RD;
						rd_q    <= SLOT_CENTER;
					end
				end
				ST_RD: begin
					rd_q <= rd_q + 3'd1;
					if (rd_q == SLOT_LAST) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					face_q  <= nf[2:0];
					vtx_q   <= '0;
					state_q <= (ctr_full_q && nf[3]) ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (load) begin
						if (vtx_q == vfcm_pkg::VTX_LAST) begin
							vtx_q <= '0;
							if (nf[3]) begin
								face_q <= nf[2:0];
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							vtx_q <= vtx_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x_q <= cell_x;
			y_q <= cell_y;
			z_q <= cell_z;
		end
		chk_idx_s1 <= rd_q;
		chk_in_s1  <= nb_in;
		if (chk_vld_s1) begin
			if (chk_idx_s1 == SLOT_CENTER) begin
				ctr_full_q <= !rd_empty;
			end else begin
				mask_q[chk_idx_s1 - 3'd1] <= rd_empty;
			end
		end
		if (load) begin
			out_vtx_q.vert_x <= 8'(x_q) + 8'(corner[4]);
			out_vtx_q.vert_y <= y_q + 8'(corner[3]);
			out_vtx_q.vert_z <= 8'(z_q) + 8'(corner[2]);
			out_vtx_q.tex_u  <= corner[1];
			out_vtx_q.tex_v  <= corner[0];
			out_vtx_q.face   <= face_q;
			out_vtx_q.last   <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_vtx   = out_vtx_q;

endmodule

>>> hw/rtl/voxel_face_cull_mesher_core.sv
// Top level of the voxel face-culling mesher: configuration registers, stream ports, core wiring.
//
// After reset the block clears its cell store one entry per cycle, all 2**(2*clog2(CHUNK_WIDTH) +
// clog2(CHUNK_HEIGHT)) entries (65536 at the default sizes), and holds s_axis_tready low until
// that pass is done; configuration writes are taken throughout. A write item leaves the input
// ready for the next item. A mesh item holds the input while the single-port store serves the
// center cell and its six neighbors in seven consecutive reads and, when the center cell is not
// empty, the faces whose neighbor is empty stream out six vertices each (up to 36). The result
// register lets the next item be accepted while the final vertex still waits on m_axis_tready.
module voxel_face_cull_mesher_core #(
	parameter int CHUNK_WIDTH  = vfcm_pkg::CHUNK_WIDTH_DEF,
	parameter int CHUNK_HEIGHT = vfcm_pkg::CHUNK_HEIGHT_DEF,
	parameter int TYPE_BITS    = vfcm_pkg::TYPE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // cell_x[3:0], cell_y[11:4], cell_z[15:12], cell_type[23:16]
	input  logic [0:0]  s_axis_tuser,   // cmd[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // base_x[15:0], base_z[31:16], vert_x[39:32],
	                                    // vert_y[47:40], vert_z[55:48], tex_u[56], tex_v[57],
	                                    // face[60:58], zero[63:61]
	output logic        m_axis_tlast,   // last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int XB = $clog2(CHUNK_WIDTH);
	localparam int YB = $clog2(CHUNK_HEIGHT);
	localparam int AW = 2 * XB + YB;

	logic [15:0]          pos_x_q;
	logic [15:0]          pos_z_q;
	logic [7:0]           empty_q;
	logic                 mem_we;
	logic [AW-1:0]        mem_addr;
	logic [TYPE_BITS-1:0] mem_wdata;
	logic [TYPE_BITS-1:0] mem_rdata;
	logic                 clr_busy;
	vfcm_pkg::vtx_t       out_vtx;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_z_q <= '0;
			empty_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				vfcm_pkg::REG_CHUNK_POS_X: pos_x_q <= cfg_data;
				vfcm_pkg::REG_CHUNK_POS_Z: pos_z_q <= cfg_data;
				vfcm_pkg::REG_EMPTY_CODE:  empty_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	vfcm_store #(
		.ADDR_W   (AW),
		.TYPE_BITS(TYPE_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (mem_we),
		.addr    (mem_addr),
		.wdata   (mem_wdata),
		.rdata   (mem_rdata),
		.clr_busy(clr_busy)
	);

	vfcm_ctrl #(
		.CHUNK_WIDTH (CHUNK_WIDTH),
		.CHUNK_HEIGHT(CHUNK_HEIGHT),
		.TYPE_BITS   (TYPE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr_busy  (clr_busy),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.cmd       (s_axis_tuser[0]),
		.cell_x    (s_axis_tdata[3:0]),
		.cell_y    (s_axis_tdata[11:4]),
		.cell_z    (s_axis_tdata[15:12]),
		.cell_type (s_axis_tdata[23:16]),
		.empty_code(empty_q),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_vtx   (out_vtx)
	);

	assign m_axis_tdata = {3'b000, out_vtx.face, out_vtx.tex_v, out_vtx.tex_u, out_vtx.vert_z,
		out_vtx.vert_y, out_vtx.vert_x, pos_z_q, pos_x_q};
	assign m_axis_tlast = out_vtx.last;

endmodule

>>> hw/rtl/vfcm_checker.sv
// Port-level checker of the voxel face-culling mesher, bound to the top level.
module vfcm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [0:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// hold a stalled vertex
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled vertex changed");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == vfcm_pkg::CMD_WRITE) &&
		!m_axis_tvalid |=> !m_axis_tvalid)
		else $error("write transfer produced a vertex");

	a_busy_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input taken before the current item finished");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[60:58] <= vfcm_pkg::FACE_RIGHT)
		else $error("face code out of range");

endmodule

bind voxel_face_cull_mesher_core vfcm_checker u_vfcm_checker (.*);
